// ===== rtl/generational_handle_table_macros.svh =====
// Assertion macros for the handle table RTL.
`ifndef GENERATIONAL_HANDLE_TABLE_MACROS_SVH
`define GENERATIONAL_HANDLE_TABLE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define GHT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("handle table check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define GHT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("handle table check failed");

`else

`define GHT_ASSERT_NOW(label, ante, cons)
`define GHT_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/ght_pkg.sv =====
// Types and codes of the generational handle table.
package ght_pkg;

  localparam int OP_W     = 2;
  localparam int KEY_W    = 16;
  localparam int SLOT_W   = 6;
  localparam int GEN_W    = 32;
  localparam int STATUS_W = 3;

  // Command codes
  localparam logic [OP_W-1:0] OP_ACQUIRE     = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP      = 2'd1;
  localparam logic [OP_W-1:0] OP_REL_SERIAL  = 2'd2;
  localparam logic [OP_W-1:0] OP_REL_KEY     = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MISMATCH  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_SLOT  = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [KEY_W-1:0]  object_key;
    logic [SLOT_W-1:0] slot_index;
    logic [GEN_W-1:0]  serial_generation;
  } ght_in_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   result_slot;
    logic [GEN_W-1:0]    result_generation;
    logic [KEY_W-1:0]    result_key;
    logic                key_present;
    logic [STATUS_W-1:0] status;
  } ght_out_t;

  // Control from the sequencer to the slot store
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic set_used;
    logic clr_used;
  } ght_mem_ctl_t;

endpackage

// ===== rtl/ght_mem.sv =====
// Slot store: key/generation memory with registered read and per-slot used flags.
module ght_mem import ght_pkg::*; #(
  parameter int SLOTS = 64,
  parameter int AW    = 6,
  parameter int DW    = 48
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ght_mem_ctl_t  ctl_i,
  input  logic [AW-1:0] rd_addr_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i,
  input  logic [AW-1:0] chk_addr_i,
  output logic [DW-1:0] rd_data_o,
  output logic          used_o
);

  logic [DW-1:0]    mem_q [SLOTS];
  logic [DW-1:0]    rd_data_q;
  logic [SLOTS-1:0] used_q;

  // Write one entry, read one entry into the output register
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (ctl_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // Set on claim, drop on release
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (ctl_i.set_used) begin
      used_q[wr_addr_i] <= 1'b1;
    end else if (ctl_i.clr_used) begin
      used_q[wr_addr_i] <= 1'b0;
    end
  end

  assign rd_data_o = rd_data_q;
  assign used_o    = used_q[chk_addr_i];

endmodule

// ===== rtl/generational_handle_table.sv =====
// Top level of the generational handle table: command sequencer and shared comparator.
//
//   channel    handshake            payload   direction
//   command    start / busy         cmd_i     in
//   response   done_o (strobe)      rsp_o     out
//
// Acquire and release by key scan every slot through the single memory read
// port, one slot a cycle, then drain the last read and finish; the result
// strobe is registered. Lookup and release by serial read one slot, then check
// it. A bad slot index is answered in the next cycle.
// Reset clears the used flags and sets the generation counter to 1; the
// key/generation memory needs no clearing. The receiver cannot stall: each
// result is on rsp_o for the single cycle in which done_o is high.
module generational_handle_table import ght_pkg::*; #(
  parameter int SLOTS    = 64,
  parameter int KEY_BITS = 16,
  parameter int GEN_BITS = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  ght_in_t  cmd_i,
  output logic     done_o,
  output ght_out_t rsp_o
);

  localparam int AW = $clog2(SLOTS);
  localparam int DW = KEY_BITS + GEN_BITS;
  localparam int CW = (KEY_BITS > GEN_BITS) ? KEY_BITS : GEN_BITS;
  localparam logic [AW-1:0]   LAST_SLOT = AW'(SLOTS - 1);
  localparam logic [SLOT_W:0] SLOTS_LIM = (SLOT_W + 1)'(SLOTS);

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_FIN   = 3'd3;
  localparam logic [2:0] S_SRD   = 3'd4;
  localparam logic [2:0] S_SCHK  = 3'd5;

  logic [2:0]          state_q, state_d;
  ght_in_t             cmd_q, cmd_d;
  logic [AW-1:0]       cnt_q, cnt_d;
  logic                pend_q, pend_d;
  logic [AW-1:0]       pend_addr_q, pend_addr_d;
  logic                hit_q, hit_d;
  logic [AW-1:0]       hit_slot_q, hit_slot_d;
  logic [GEN_BITS-1:0] hit_gen_q, hit_gen_d;
  logic [KEY_BITS-1:0] hit_key_q, hit_key_d;
  logic                free_q, free_d;
  logic [AW-1:0]       free_slot_q, free_slot_d;
  logic [GEN_BITS-1:0] next_gen_q, next_gen_d;
  ght_out_t            rsp_q, rsp_d;
  logic                done_q, done_d;

  ght_mem_ctl_t        mem_ctl;
  logic [AW-1:0]       rd_addr, wr_addr, chk_addr;
  logic [DW-1:0]       wr_data, rd_data;
  logic                used_chk;

  logic [KEY_BITS-1:0] key_w, rd_key;
  logic [GEN_BITS-1:0] sgen_w, rd_gen, gen_eff, gen_inc;
  logic [AW-1:0]       idx_w;
  logic                serial_mode;
  logic [CW-1:0]       cmp_a, cmp_b;
  logic                cmp_eq;

  ght_mem #(
    .SLOTS (SLOTS),
    .AW    (AW),
    .DW    (DW)
  ) u_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (mem_ctl),
    .rd_addr_i  (rd_addr),
    .wr_addr_i  (wr_addr),
    .wr_data_i  (wr_data),
    .chk_addr_i (chk_addr),
    .rd_data_o  (rd_data),
    .used_o     (used_chk)
  );

  // Fit the command fields to the stored widths
  assign key_w  = KEY_BITS'(cmd_q.object_key);
  assign sgen_w = GEN_BITS'(cmd_q.serial_generation);
  assign idx_w  = cmd_q.slot_index[AW-1:0];
  assign rd_key = rd_data[DW-1:GEN_BITS];
  assign rd_gen = rd_data[GEN_BITS-1:0];
  assign wr_data = {key_w, next_gen_q};

  assign serial_mode = (cmd_q.operation == OP_LOOKUP) ||
                       (cmd_q.operation == OP_REL_SERIAL);
  assign chk_addr    = serial_mode ? idx_w : pend_addr_q;
  assign gen_eff     = used_chk ? rd_gen : '0;

  // Shared comparator: key match while scanning, generation check on a serial
  assign cmp_a  = serial_mode ? CW'(sgen_w) : CW'(key_w);
  assign cmp_b  = serial_mode ? CW'(gen_eff) : CW'(rd_key);
  assign cmp_eq = (cmp_a == cmp_b);

  // Advance the generation, skipping zero on wrap
  assign gen_inc = next_gen_q + 1'b1;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    pend_addr_d = pend_addr_q;
    hit_d       = hit_q;
    hit_slot_d  = hit_slot_q;
    hit_gen_d   = hit_gen_q;
    hit_key_d   = hit_key_q;
    free_d      = free_q;
    free_slot_d = free_slot_q;
    next_gen_d  = next_gen_q;
    rsp_d       = rsp_q;
    done_d      = 1'b0;
    mem_ctl     = '0;
    rd_addr     = cnt_q;
    wr_addr     = hit_slot_q;

    // Judge the slot whose data has just come out of the memory
    if (((state_q == S_SCAN) || (state_q == S_DRAIN)) && pend_q) begin
      if (used_chk && cmp_eq && !hit_q) begin
        hit_d      = 1'b1;
        hit_slot_d = pend_addr_q;
        hit_gen_d  = rd_gen;
        hit_key_d  = rd_key;
      end
      if (!used_chk && !free_q) begin
        free_d      = 1'b1;
        free_slot_d = pend_addr_q;
      end
    end

    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_d = cmd_i;
          if ((cmd_i.operation == OP_ACQUIRE) || (cmd_i.operation == OP_REL_KEY)) begin
            state_d = S_SCAN;
            cnt_d   = '0;
            pend_d  = 1'b0;
            hit_d   = 1'b0;
            free_d  = 1'b0;
          end else if ({1'b0, cmd_i.slot_index} >= SLOTS_LIM) begin
            rsp_d.result_slot       = cmd_i.slot_index;
            rsp_d.result_generation = '0;
            rsp_d.result_key        = '0;
            rsp_d.key_present       = 1'b0;
            rsp_d.status            = ST_BAD_SLOT;
            done_d                  = 1'b1;
          end else begin
            state_d = S_SRD;
          end
        end
      end

      S_SCAN: begin
        mem_ctl.rd_en = 1'b1;
        rd_addr       = cnt_q;
        pend_d        = 1'b1;
        pend_addr_d   = cnt_q;
        cnt_d         = cnt_q + 1'b1;
        if (cnt_q == LAST_SLOT) begin
          state_d = S_DRAIN;
        end
      end

      S_DRAIN: begin
        pend_d  = 1'b0;
        state_d = S_FIN;
      end

      S_FIN: begin
        state_d = S_IDLE;
        done_d  = 1'b1;
        if (hit_q) begin
          rsp_d.result_slot       = SLOT_W'(hit_slot_q);
          rsp_d.result_generation = GEN_W'(hit_gen_q);
          rsp_d.result_key        = KEY_W'(hit_key_q);
          rsp_d.key_present       = 1'b1;
          rsp_d.status            = ST_OK;
          if (cmd_q.operation == OP_REL_KEY) begin
            mem_ctl.clr_used = 1'b1;
            wr_addr          = hit_slot_q;
          end
        end else if (cmd_q.operation == OP_ACQUIRE) begin
          // Claim the lowest free slot, or reuse slot zero when full
          wr_addr          = free_q ? free_slot_q : '0;
          mem_ctl.wr_en    = 1'b1;
          mem_ctl.set_used = 1'b1;
          next_gen_d       = (gen_inc == '0) ? GEN_BITS'(1) : gen_inc;
          rsp_d.result_slot       = free_q ? SLOT_W'(free_slot_q) : '0;
          rsp_d.result_generation = GEN_W'(next_gen_q);
          rsp_d.result_key        = KEY_W'(key_w);
          rsp_d.key_present       = 1'b1;
          rsp_d.status            = free_q ? ST_OK : ST_FULL;
        end else begin
          rsp_d.result_slot       = '0;
          rsp_d.result_generation = '0;
          rsp_d.result_key        = '0;
          rsp_d.key_present       = 1'b0;
          rsp_d.status            = ST_NOT_FOUND;
        end
      end

      S_SRD: begin
        mem_ctl.rd_en = 1'b1;
        rd_addr       = idx_w;
        state_d       = S_SCHK;
      end

      S_SCHK: begin
        state_d                 = S_IDLE;
        done_d                  = 1'b1;
        rsp_d.result_slot       = cmd_q.slot_index;
        rsp_d.result_generation = GEN_W'(gen_eff);
        rsp_d.result_key        = used_chk ? KEY_W'(rd_key) : '0;
        rsp_d.key_present       = used_chk;
        rsp_d.status            = cmp_eq ? ST_OK : ST_MISMATCH;
        if (cmd_q.operation == OP_REL_SERIAL) begin
          mem_ctl.clr_used = 1'b1;
          wr_addr          = idx_w;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      pend_q     <= 1'b0;
      hit_q      <= 1'b0;
      free_q     <= 1'b0;
      next_gen_q <= GEN_BITS'(1);
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      pend_q     <= pend_d;
      hit_q      <= hit_d;
      free_q     <= free_d;
      next_gen_q <= next_gen_d;
      done_q     <= done_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    pend_addr_q <= pend_addr_d;
    hit_slot_q  <= hit_slot_d;
    hit_gen_q   <= hit_gen_d;
    hit_key_q   <= hit_key_d;
    free_slot_q <= free_slot_d;
    rsp_q       <= rsp_d;
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

`include "generational_handle_table_macros.svh"

  // A result beat only ever leaves with the sequencer back at rest
  `GHT_ASSERT_NOW(a_done_idle, done_o, !busy)
  // The generation counter never holds zero
  `GHT_ASSERT_NOW(a_gen_nonzero, 1'b1, next_gen_q != '0)
  // An accepted command either starts work or answers at once
  `GHT_ASSERT_NEXT(a_accept_moves, start && !busy, busy || done_o)
  // A drain always moves on to the finish state with no read pending
  `GHT_ASSERT_NEXT(a_drain_order, state_q == S_DRAIN, state_q == S_FIN && !pend_q)

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the generational handle table.
`timescale 1ns / 1ps

module testbench import ght_pkg::*; ();

  localparam int SLOT_COUNT   = 64;
  localparam int RANDOM_ITEMS = 500;
  localparam int CALM_ITEMS   = 60;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 80;
  localparam int POOL_SIZE    = 32;

  // Shadow copy of the slot store: predicts each response and holds them in order
  class handle_table_shadow;
    bit [KEY_W-1:0] key_mem [SLOT_COUNT];
    bit [GEN_W-1:0] gen_mem [SLOT_COUNT];
    bit             used    [SLOT_COUNT];
    bit             written [SLOT_COUNT];
    bit [GEN_W-1:0] gen_next;
    ght_out_t       expected_rsp [$];
    int             errors;
    int             checked;
    int             status_tally [5];

    function new();
      gen_next = 1;
      errors   = 0;
      checked  = 0;
    endfunction

    function int find_key(bit [KEY_W-1:0] k);
      for (int i = 0; i < SLOT_COUNT; i++)
        if (used[i] && key_mem[i] == k) return i;
      return -1;
    endfunction

    function int lowest_free();
      for (int i = 0; i < SLOT_COUNT; i++)
        if (!used[i]) return i;
      return -1;
    endfunction

    // Favour slots that have been stamped at least once
    function int pick_written_slot();
      int cand [$];
      foreach (written[i]) if (written[i]) cand.push_back(i);
      if (cand.size() == 0) return -1;
      return cand[$urandom_range(0, cand.size() - 1)];
    endfunction

    function void clear_slot(int s);
      gen_mem[s] = '0;
      key_mem[s] = '0;
      used[s]    = 1'b0;
    endfunction

    // Advance the shadow state by one accepted command beat
    function void note_command(ght_in_t c);
      ght_out_t e;
      int s;
      e = '0;
      case (c.operation)
        OP_ACQUIRE: begin
          e.status = ST_OK;
          s = find_key(c.object_key);
          if (s < 0) begin
            s = lowest_free();
            if (s < 0) begin
              s = 0;
              e.status = ST_FULL;
            end
            gen_mem[s] = gen_next;
            key_mem[s] = c.object_key;
            used[s]    = 1'b1;
            written[s] = 1'b1;
            gen_next   = gen_next + 1;
            // skip zero on wrap so a live slot never carries generation zero
            if (gen_next == '0) gen_next = 1;
          end
          e.result_slot       = s[SLOT_W-1:0];
          e.result_generation = gen_mem[s];
          e.result_key        = key_mem[s];
          e.key_present       = 1'b1;
        end
        OP_REL_KEY: begin
          s = find_key(c.object_key);
          if (s < 0) begin
            e.status = ST_NOT_FOUND;
          end else begin
            e.result_slot       = s[SLOT_W-1:0];
            e.result_generation = gen_mem[s];
            e.result_key        = key_mem[s];
            e.key_present       = 1'b1;
            e.status            = ST_OK;
            clear_slot(s);
          end
        end
        default: begin
          s = int'(c.slot_index);
          e.result_slot = c.slot_index;
          if (s >= SLOT_COUNT) begin
            e.status = ST_BAD_SLOT;
          end else begin
            e.result_generation = gen_mem[s];
            e.result_key        = used[s] ? key_mem[s] : '0;
            e.key_present       = used[s];
            e.status = (c.serial_generation != gen_mem[s]) ? ST_MISMATCH : ST_OK;
            // a release by serial frees the slot even on a mismatch
            if (c.operation == OP_REL_SERIAL) clear_slot(s);
          end
        end
      endcase
      status_tally[int'(e.status)]++;
      expected_rsp.push_back(e);
    endfunction

    function void report(string what, ght_out_t e, ght_out_t r);
      errors++;
      if (errors <= 10)
        $display({"MISMATCH %s: exp slot %0d gen %0h key %0h pres %0b st %0d",
                  " | got slot %0d gen %0h key %0h pres %0b st %0d"},
                 what, e.result_slot, e.result_generation, e.result_key, e.key_present,
                 e.status, r.result_slot, r.result_generation, r.result_key, r.key_present,
                 r.status);
    endfunction

    // Compare one response beat with the oldest prediction
    function void check_response(ght_out_t r);
      ght_out_t e;
      checked++;
      if (expected_rsp.size() == 0) begin
        report("unexpected response", '0, r);
        return;
      end
      e = expected_rsp.pop_front();
      if (r.result_slot !== e.result_slot || r.result_generation !== e.result_generation ||
          r.result_key !== e.result_key || r.key_present !== e.key_present ||
          r.status !== e.status)
        report("response", e, r);
    endfunction
  endclass

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  ght_in_t  cmd;
  logic     done_o;
  ght_out_t rsp;

  handle_table_shadow shadow = new();
  bit [KEY_W-1:0]     key_pool [POOL_SIZE];
  bit                 idle_en;
  int                 sent;
  int                 stall_cycles;

  generational_handle_table #(
    .SLOTS    (SLOT_COUNT),
    .KEY_BITS (KEY_W),
    .GEN_BITS (GEN_W)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_i  (cmd),
    .done_o (done_o),
    .rsp_o  (rsp)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Check every strobed response beat
  always @(posedge clk_i) begin
    if (rst_ni && done_o) shadow.check_response(rsp);
  end

  // Abort when nothing moves on either side for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Assemble a command; fields the operation ignores carry noise
  function automatic ght_in_t build_cmd(logic [OP_W-1:0] op, bit [KEY_W-1:0] k, int s,
                                        bit [GEN_W-1:0] g);
    ght_in_t c;
    c.operation         = op;
    c.object_key        = k;
    c.slot_index        = s[SLOT_W-1:0];
    c.serial_generation = g;
    if (op == OP_ACQUIRE || op == OP_REL_KEY) begin
      c.slot_index        = SLOT_W'($urandom);
      c.serial_generation = $urandom;
    end else begin
      c.object_key = KEY_W'($urandom);
    end
    return c;
  endfunction

  function automatic bit [KEY_W-1:0] pool_key();
    if ($urandom_range(0, 4) == 0) return KEY_W'($urandom);
    return key_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  // Half the time the live generation, otherwise an edge value or noise
  function automatic bit [GEN_W-1:0] probe_gen(int s);
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return $urandom;
      default: return shadow.gen_mem[s];
    endcase
  endfunction

  // Present one command beat, with an optional idle burst ahead of it
  task automatic send_cmd(ght_in_t c);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk_i); while (busy);
    shadow.note_command(c);
    sent++;
  endtask

  // Fill the table, reuse slot 0 when full, then sweep every slot by serial
  task automatic fill_round();
    while (shadow.lowest_free() >= 0)
      send_cmd(build_cmd(OP_ACQUIRE, KEY_W'($urandom), 0, 0));
    repeat (2) send_cmd(build_cmd(OP_ACQUIRE, KEY_W'($urandom), 0, 0));
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if ($urandom_range(0, 1) == 0)
        send_cmd(build_cmd(OP_LOOKUP, 0, i, probe_gen(i)));
      else
        send_cmd(build_cmd(OP_REL_SERIAL, 0, i, probe_gen(i)));
    end
  endtask

  // Acquire a key, use its serial, then mostly give it back
  task automatic run_session();
    bit [KEY_W-1:0] k;
    bit [GEN_W-1:0] g;
    int s;
    k = pool_key();
    send_cmd(build_cmd(OP_ACQUIRE, k, 0, 0));
    s = shadow.find_key(k);
    g = shadow.gen_mem[s];
    if ($urandom_range(0, 3) != 0) send_cmd(build_cmd(OP_LOOKUP, 0, s, g));
    if ($urandom_range(0, 3) == 0)
      send_cmd(build_cmd(OP_LOOKUP, 0, s, g ^ (32'd1 << $urandom_range(0, 31))));
    case ($urandom_range(0, 4))
      0, 1: send_cmd(build_cmd(OP_REL_SERIAL, 0, s, g));
      2:    send_cmd(build_cmd(OP_REL_KEY, k, 0, 0));
      3: begin
        // release, then probe with the now stale serial
        send_cmd(build_cmd(OP_REL_SERIAL, 0, s, g));
        send_cmd(build_cmd(OP_LOOKUP, 0, s, g));
      end
      default: ;
    endcase
  endtask

  // Any operation with loosely chosen operands
  task automatic run_noise();
    logic [OP_W-1:0] op;
    int s;
    op = OP_W'($urandom_range(OP_ACQUIRE, OP_REL_KEY));
    s  = shadow.pick_written_slot();
    if (s < 0 || $urandom_range(0, 7) == 0) s = $urandom_range(0, SLOT_COUNT - 1);
    send_cmd(build_cmd(op, pool_key(), s, probe_gen(s)));
  endtask

  initial begin
    int  target;
    int  midpoint;
    bit  refilled;
    rst_ni   = 1'b0;
    start    = 1'b0;
    cmd      = '0;
    idle_en  = 1'b1;
    sent     = 0;
    refilled = 1'b0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = KEY_W'($urandom);
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Slots never stamped: generation zero matches, anything else does not
    send_cmd(build_cmd(OP_LOOKUP, 0, 5, '0));
    send_cmd(build_cmd(OP_LOOKUP, 0, 63, 32'h1));
    // Key extremes and a repeat acquire of a held key
    send_cmd(build_cmd(OP_ACQUIRE, 16'h0000, 0, 0));
    send_cmd(build_cmd(OP_ACQUIRE, 16'hFFFF, 0, 0));
    send_cmd(build_cmd(OP_ACQUIRE, 16'h0000, 0, 0));
    // Matching and mismatching serials, release of a mismatched serial
    send_cmd(build_cmd(OP_LOOKUP, 0, 0, shadow.gen_mem[0]));
    send_cmd(build_cmd(OP_LOOKUP, 0, 1, '1));
    send_cmd(build_cmd(OP_REL_SERIAL, 0, 1, '0));
    // Free slot: generation zero matches, anything else does not
    send_cmd(build_cmd(OP_LOOKUP, 0, 1, '0));
    send_cmd(build_cmd(OP_LOOKUP, 0, 1, 32'h5));
    send_cmd(build_cmd(OP_REL_SERIAL, 0, 1, '0));
    // Release by key: absent, then present
    send_cmd(build_cmd(OP_REL_KEY, 16'hFFFF, 0, 0));
    send_cmd(build_cmd(OP_REL_KEY, 16'h0000, 0, 0));
    // Lowest free slot is claimed again after a release
    send_cmd(build_cmd(OP_ACQUIRE, 16'hA5A5, 0, 0));
    send_cmd(build_cmd(OP_ACQUIRE, 16'h5A5A, 0, 0));
    send_cmd(build_cmd(OP_REL_SERIAL, 0, 0, shadow.gen_mem[0]));
    send_cmd(build_cmd(OP_ACQUIRE, 16'h1234, 0, 0));
    send_cmd(build_cmd(OP_REL_KEY, 16'h5A5A, 0, 0));
    send_cmd(build_cmd(OP_LOOKUP, 0, 1, '1));

    // Random part: full-table rounds, sessions and noise; calm towards the end
    target   = sent + RANDOM_ITEMS;
    midpoint = sent + RANDOM_ITEMS / 2;
    fill_round();
    while (sent < target) begin
      idle_en = (sent < target - CALM_ITEMS);
      if (!refilled && sent >= midpoint) begin
        refilled = 1'b1;
        fill_round();
      end else if ($urandom_range(0, 7) < 5) begin
        run_session();
      end else begin
        run_noise();
      end
    end
    start <= 1'b0;

    // Drain outstanding responses, then watch for strays
    while (shadow.expected_rsp.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d commands, checked %0d responses, %0d failures",
             sent, shadow.checked, shadow.errors);
    $display("Status mix: ok %0d, mismatch %0d, full reuse %0d, key absent %0d",
             shadow.status_tally[ST_OK], shadow.status_tally[ST_MISMATCH],
             shadow.status_tally[ST_FULL], shadow.status_tally[ST_NOT_FOUND]);
    if (shadow.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
